@@ design/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for the skinning pipeline
// widths of the fixed point stages, palette beat structs and command codes
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

  // defaults for the top level parameters
  localparam int unsigned MAX_JOINTS_DEF = 64;
  localparam int unsigned INFLUENCES_DEF = 4;

  // influences carried by the input ports
  localparam int unsigned PORT_INF = 4;

  // matrix layout: three rows of four, element = row*4 + col
  localparam int unsigned NUM_ROWS    = 3;
  localparam int unsigned NUM_COLS    = 4;
  localparam int unsigned MAT_ENTRIES = NUM_ROWS * NUM_COLS;

  // field widths
  localparam int unsigned Q_W    = 32;  // signed q16.16
  localparam int unsigned W_W    = 16;  // unsigned q1.15
  localparam int unsigned IDX_W  = 8;   // joint index byte
  localparam int unsigned ELEM_W = 4;
  localparam int unsigned JC_W   = 7;

  // internal stage widths
  localparam int unsigned PROD_W  = 2 * Q_W;      // entry times coordinate
  localparam int unsigned ACC_W   = PROD_W + 1;   // three products plus offset
  localparam int unsigned ROW_W   = 49;           // floored row result
  localparam int unsigned FULL_W  = ROW_W + W_W + 1;
  localparam int unsigned WPROD_W = 64;           // row times weight
  localparam int unsigned SUM_W   = WPROD_W + 2;  // four weighted terms
  localparam int unsigned TOT_W   = SUM_W - 15;   // floored total

  localparam logic [JC_W-1:0] JOINT_COUNT_RESET = JC_W'(64);
  localparam logic [W_W-1:0]  WEIGHT_ONE        = 16'h8000;
  localparam logic [Q_W-1:0]  Q_MAX             = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]  Q_MIN             = 32'h8000_0000;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SKIN = 1'b1
  } command_e;

  typedef logic [MAT_ENTRIES-1:0][Q_W-1:0] mat_t;

  // palette write beat, broadcast to every copy
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  joint;
    logic [ELEM_W-1:0] elem;
    logic [Q_W-1:0]    data;
  } wr_t;

  // palette read request for one influence
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] joint;
    logic             active;
  } rd_t;

endpackage

`default_nettype wire

@@ design/linear_blend_skinning_vertex.sv @@
// ----------------------------------------------------------------------------
// linear_blend_skinning_vertex: four influence linear blend skinning
// palette of affine joint matrices, weighted blend, saturated q16.16 result
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+-----------------------------------
//  in       | in  | in_valid_i / in_stall_o   | command, load_*, pos_*, joints, weights
//  out      | out | out_valid_o / out_stall_i | skinned_x/y/z, saturated
//  cfg      | in  | cfg_valid_i / cfg_ready_o | joint_count (7 bits)
//
//  one beat per cycle on the input while in_stall_o is low; a skin result moves through
//  the register stages below into the output register, where it is offered
//  six register stages: palette read, 36 entry products, row sums, weighting,
//  blend sum, clamp into the output register; at most one multiplier level per stage
//  a load writes the palette at its beat and is seen by a skin in the next cycle
//  reset clears the valid bits and sets joint_count to 64; the palette is not cleared
//  each stage advances when the stage after it is empty or moving, so bubbles
//  close up under an output stall and the input stalls only with all stages full
// ----------------------------------------------------------------------------
`default_nettype none

module linear_blend_skinning_vertex #(
  parameter int unsigned MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF,
  parameter int unsigned INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lbs_pkg::JC_W-1:0]        cfg_data_i,

  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [5:0]                      load_joint_i,
  input  logic [lbs_pkg::ELEM_W-1:0]      load_element_i,
  input  logic signed [lbs_pkg::Q_W-1:0]  load_value_i,
  input  logic signed [lbs_pkg::Q_W-1:0]  pos_x_i,
  input  logic signed [lbs_pkg::Q_W-1:0]  pos_y_i,
  input  logic signed [lbs_pkg::Q_W-1:0]  pos_z_i,
  input  logic [31:0]                     joint_indices_i,
  input  logic [lbs_pkg::W_W-1:0]         weight_0_i,
  input  logic [lbs_pkg::W_W-1:0]         weight_1_i,
  input  logic [lbs_pkg::W_W-1:0]         weight_2_i,
  input  logic [lbs_pkg::W_W-1:0]         weight_3_i,

  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [lbs_pkg::Q_W-1:0]  skinned_x_o,
  output logic signed [lbs_pkg::Q_W-1:0]  skinned_y_o,
  output logic signed [lbs_pkg::Q_W-1:0]  skinned_z_o,
  output logic                            saturated_o
);
  import lbs_pkg::*;

  // only the first four influences exist on the ports
  localparam int unsigned NUM_INF = (INFLUENCES < PORT_INF) ? INFLUENCES : PORT_INF;
  localparam int unsigned LIM_W   = IDX_W + 1;

  // --------------------------------------------------------------------------
  // stage enables: a stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !out_valid_q || !out_stall_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;

  logic in_beat;
  assign in_beat = in_valid_i && en1;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [JC_W-1:0] joint_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_count_q <= JOINT_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      joint_count_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: influence qualification, palette read, palette load
  // --------------------------------------------------------------------------
  logic [W_W-1:0]   w_in [PORT_INF];
  logic [LIM_W-1:0] limit;
  logic [IDX_W-1:0] jsel [NUM_INF];
  logic             act  [NUM_INF];
  logic [W_W-1:0]   w1_d [NUM_INF];

  assign w_in[0] = weight_0_i;
  assign w_in[1] = weight_1_i;
  assign w_in[2] = weight_2_i;
  assign w_in[3] = weight_3_i;

  // joints in use never exceed the palette size
  assign limit = (LIM_W'(joint_count_q) < LIM_W'(MAX_JOINTS)) ?
                 LIM_W'(joint_count_q) : LIM_W'(MAX_JOINTS);

  always_comb begin
    for (int k = 0; k < NUM_INF; k++) begin
      jsel[k] = joint_indices_i[IDX_W*k +: IDX_W];
      // skipped on zero weight or joint beyond the ones in use
      act[k]  = (w_in[k] != '0) && (LIM_W'(jsel[k]) < limit);
      // weights above one clamp to one; a skipped influence weighs nothing
      w1_d[k] = !act[k] ? '0 : ((w_in[k] > WEIGHT_ONE) ? WEIGHT_ONE : w_in[k]);
    end
  end

  wr_t  pal_wr;
  rd_t  pal_rd [NUM_INF];
  mat_t mat    [NUM_INF];

  // loads outside the palette or past element eleven are dropped
  assign pal_wr.en    = in_beat && (command_i == CMD_LOAD) &&
                        (LIM_W'(load_joint_i) < LIM_W'(MAX_JOINTS)) &&
                        (load_element_i < ELEM_W'(MAT_ENTRIES));
  assign pal_wr.joint = IDX_W'(load_joint_i);
  assign pal_wr.elem  = load_element_i;
  assign pal_wr.data  = load_value_i;

  // one palette copy per influence gives each its own read port
  for (genvar k = 0; k < NUM_INF; k++) begin : g_inf
    assign pal_rd[k].en     = en1;
    assign pal_rd[k].joint  = jsel[k];
    assign pal_rd[k].active = act[k];

    lbs_palette #(
      .MAX_JOINTS (MAX_JOINTS)
    ) u_palette (
      .clk_i (clk_i),
      .wr_i  (pal_wr),
      .rd_i  (pal_rd[k]),
      .mat_o (mat[k])
    );
  end

  logic signed [Q_W-1:0] pos_q [NUM_COLS-1];
  logic [W_W-1:0]        w1_q  [NUM_INF];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      w1_q     <= w1_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: matrix entry times coordinate, 32 by 32 each
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_d [NUM_INF][NUM_ROWS][NUM_COLS-1];
  logic signed [PROD_W-1:0] prod_q [NUM_INF][NUM_ROWS][NUM_COLS-1];
  logic signed [Q_W-1:0]    m3_d   [NUM_INF][NUM_ROWS];
  logic signed [Q_W-1:0]    m3_q   [NUM_INF][NUM_ROWS];
  logic [W_W-1:0]           w2_q   [NUM_INF];

  always_comb begin
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS - 1; c++) begin
          prod_d[k][r][c] = $signed(mat[k][r*NUM_COLS + c]) * pos_q[c];
        end
        // translation column, w is one
        m3_d[k][r] = $signed(mat[k][r*NUM_COLS + NUM_COLS - 1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_q <= prod_d;
      m3_q   <= m3_d;
      w2_q   <= w1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: row sum, floored once to q16.16 (same as the split floor)
  // --------------------------------------------------------------------------
  logic signed [ROW_W-1:0] row_d [NUM_INF][NUM_ROWS];
  logic signed [ROW_W-1:0] row_q [NUM_INF][NUM_ROWS];
  logic [W_W-1:0]          w3_q  [NUM_INF];

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_sh;
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc = ACC_W'(prod_q[k][r][0]) + ACC_W'(prod_q[k][r][1]) +
              ACC_W'(prod_q[k][r][2]) + (ACC_W'(m3_q[k][r]) <<< 16);
        acc_sh      = acc >>> 16;
        row_d[k][r] = acc_sh[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      row_q <= row_d;
      w3_q  <= w2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: row result times weight
  // --------------------------------------------------------------------------
  logic signed [WPROD_W-1:0] wprod_d [NUM_INF][NUM_ROWS];
  logic signed [WPROD_W-1:0] wprod_q [NUM_INF][NUM_ROWS];

  always_comb begin
    logic signed [FULL_W-1:0] full;
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        full          = row_q[k][r] * $signed({1'b0, w3_q[k]});
        wprod_d[k][r] = full[WPROD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      wprod_q <= wprod_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: blend sum over influences, floored to q16.16
  // --------------------------------------------------------------------------
  logic signed [TOT_W-1:0] tot_d [NUM_ROWS];
  logic signed [TOT_W-1:0] tot_q [NUM_ROWS];

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_sh;
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum = '0;
      for (int k = 0; k < NUM_INF; k++) begin
        sum = sum + SUM_W'(wprod_q[k][r]);
      end
      sum_sh   = sum >>> 15;
      tot_d[r] = sum_sh[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      tot_q <= tot_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: clamp to 32 bits into the output register
  // --------------------------------------------------------------------------
  logic [Q_W-1:0] res_d [NUM_ROWS];
  logic           sat_d;
  logic [Q_W-1:0] res_q [NUM_ROWS];
  logic           sat_q;

  always_comb begin
    logic ovf;
    sat_d = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      // out of range when the bits above bit 31 are not all sign copies
      ovf = !((&tot_q[r][TOT_W-1:Q_W-1]) || !(|tot_q[r][TOT_W-1:Q_W-1]));
      if (ovf) begin
        res_d[r] = tot_q[r][TOT_W-1] ? Q_MIN : Q_MAX;
      end else begin
        res_d[r] = tot_q[r][Q_W-1:0];
      end
      sat_d = sat_d || ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  // --------------------------------------------------------------------------
  // valid bits; loads leave the pipe at their beat
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i && (command_i == CMD_SKIN);
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        out_valid_q <= v5_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign skinned_x_o = res_q[0];
  assign skinned_y_o = res_q[1];
  assign skinned_z_o = res_q[2];
  assign saturated_o = sat_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // a load beat never turns into a result
  a_load_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_LOAD)) |=> !v1_q)
    else $error("load beat entered the pipeline");

  // the input stalls only when every stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && out_valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // an item waiting behind a stalled result is kept
  a_hold_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && out_valid_q && out_stall_i) |=> v5_q)
    else $error("item behind a stalled result was lost");

  // a saturated result has a coordinate at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (skinned_x_o == Q_MAX || skinned_x_o == Q_MIN ||
       skinned_y_o == Q_MAX || skinned_y_o == Q_MIN ||
       skinned_z_o == Q_MAX || skinned_z_o == Q_MIN))
    else $error("saturation flag without a clamped coordinate");

endmodule

`default_nettype wire

@@ design/lbs_palette.sv @@
// ----------------------------------------------------------------------------
// lbs_palette: one copy of the joint palette
// twelve memories of one entry per joint, all read in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_palette #(
  parameter int unsigned MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF
) (
  input  logic         clk_i,
  input  lbs_pkg::wr_t wr_i,
  input  lbs_pkg::rd_t rd_i,
  output lbs_pkg::mat_t mat_o
);
  import lbs_pkg::*;

  localparam int unsigned JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic [JW-1:0] wr_addr;
  logic [JW-1:0] rd_addr;

  assign wr_addr = wr_i.joint[JW-1:0];
  assign rd_addr = rd_i.joint[JW-1:0];

  for (genvar e = 0; e < MAT_ENTRIES; e++) begin : g_elem
    logic [Q_W-1:0] mem_q [MAX_JOINTS];
    logic [Q_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.elem == ELEM_W'(e))) begin
        mem_q[wr_addr] <= wr_i.data;
      end
    end

    // skipped influences read as zero so nothing unwritten leaks through
    always_ff @(posedge clk_i) begin
      if (rd_i.en) begin
        rd_q <= rd_i.active ? mem_q[rd_addr] : '0;
      end
    end

    assign mat_o[e] = rd_q;
  end

endmodule

`default_nettype wire

@@ sim/tb_linear_blend_skinning_vertex.sv @@
// ----------------------------------------------------------------------------
// tb_linear_blend_skinning_vertex: self-checking bench for the skinning block
// loads joint matrices into the palette, skins vertices under several joint
// counts and compares every blended position with a local fixed point predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linear_blend_skinning_vertex;
  timeunit 1ns;
  timeprecision 1ps;

  import lbs_pkg::*;

  // base wait length used when draining the pipeline
  localparam int RESULT_LATENCY = 5;
  // share of cycles in which either side idles
  localparam int IDLE_PCT = 17;
  localparam int RANDOM_PER_PHASE = 100;
  // receiver hold-off for the back pressure test
  localparam int HOLD_CYCLES = 150;
  // longest quiet stretch is the hold-off plus a few idle waits; allow plenty more
  localparam int WATCHDOG_LIMIT = 2000;

  // wide enough for three 64-bit products plus offset, and for the weighted sums
  localparam int WIDE = 96;
  localparam logic signed [WIDE-1:0] SAT_HI = 96'sh7FFF_FFFF;
  localparam logic signed [WIDE-1:0] SAT_LO = -96'sh8000_0000;

  typedef struct packed {
    command_e                     cmd;
    logic [5:0]                   joint;
    logic [ELEM_W-1:0]            elem;
    logic [Q_W-1:0]               value;
    logic [Q_W-1:0]               px;
    logic [Q_W-1:0]               py;
    logic [Q_W-1:0]               pz;
    logic [31:0]                  jidx;
    logic [PORT_INF-1:0][W_W-1:0] wt;
  } beat_t;

  // xyz[0] is x
  typedef struct packed {
    logic [NUM_ROWS-1:0][Q_W-1:0] xyz;
    logic                         sat;
  } blend_t;

  logic clk;
  logic rst_n;

  logic            cfg_valid;
  logic            cfg_ready;
  logic [JC_W-1:0] cfg_data;

  logic              in_valid;
  logic              in_stall;
  logic              command;
  logic [5:0]        load_joint;
  logic [ELEM_W-1:0] load_element;
  logic [Q_W-1:0]    load_value;
  logic [Q_W-1:0]    pos_x;
  logic [Q_W-1:0]    pos_y;
  logic [Q_W-1:0]    pos_z;
  logic [31:0]       joint_indices;
  logic [W_W-1:0]    weight_0;
  logic [W_W-1:0]    weight_1;
  logic [W_W-1:0]    weight_2;
  logic [W_W-1:0]    weight_3;

  logic           out_valid;
  logic           out_stall;
  logic [Q_W-1:0] skinned_x;
  logic [Q_W-1:0] skinned_y;
  logic [Q_W-1:0] skinned_z;
  logic           saturated;

  // predictor state: palette image, which entries hold data, joint count
  logic [Q_W-1:0]         palette_img [MAX_JOINTS_DEF][MAT_ENTRIES];
  logic [MAT_ENTRIES-1:0] entry_written [MAX_JOINTS_DEF];
  bit                     joint_ready [MAX_JOINTS_DEF];
  int                     ready_joints [$];
  logic [JC_W-1:0]        joints_in_use;

  blend_t pending_blends [$];
  int     mismatches;
  int     quiet_cycles;

  // idling controls for the sender and the receiver process
  bit in_quiet;
  bit out_quiet;
  int hold_req;

  linear_blend_skinning_vertex dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .load_joint_i    (load_joint),
    .load_element_i  (load_element),
    .load_value_i    (load_value),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .pos_z_i         (pos_z),
    .joint_indices_i (joint_indices),
    .weight_0_i      (weight_0),
    .weight_1_i      (weight_1),
    .weight_2_i      (weight_2),
    .weight_3_i      (weight_3),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .skinned_x_o     (skinned_x),
    .skinned_y_o     (skinned_y),
    .skinned_z_o     (skinned_z),
    .saturated_o     (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic logic signed [WIDE-1:0] wide(input logic [Q_W-1:0] v);
    return {{(WIDE-Q_W){v[Q_W-1]}}, v};
  endfunction

  // a load only lands for elements 0..11; a joint is usable once all twelve are set
  function automatic void store_element(input beat_t b);
    if (b.elem < MAT_ENTRIES) begin
      palette_img[b.joint][b.elem] = b.value;
      entry_written[b.joint][b.elem] = 1'b1;
      if (&entry_written[b.joint] && !joint_ready[b.joint]) begin
        joint_ready[b.joint] = 1'b1;
        ready_joints.push_back(int'(b.joint));
      end
    end
  endfunction

  // each row is floored to q16.16, weighted sums are floored once at the end
  function automatic blend_t blend_vertex(input beat_t b);
    logic signed [WIDE-1:0] pos [NUM_ROWS];
    logic signed [WIDE-1:0] acc [NUM_ROWS];
    logic signed [WIDE-1:0] row;
    logic signed [WIDE-1:0] wt;
    logic signed [WIDE-1:0] tot;
    logic [W_W-1:0]         w;
    logic [IDX_W-1:0]       j;
    int unsigned            lim;
    int                     k;
    int                     r;
    int                     c;
    blend_t                 res;
    pos[0] = wide(b.px);
    pos[1] = wide(b.py);
    pos[2] = wide(b.pz);
    for (r = 0; r < NUM_ROWS; r++) acc[r] = '0;
    lim = (joints_in_use < MAX_JOINTS_DEF) ? joints_in_use : MAX_JOINTS_DEF;
    for (k = 0; k < INFLUENCES_DEF; k++) begin
      j = b.jidx[IDX_W*k +: IDX_W];
      // weights above one count as one
      w = (b.wt[k] > WEIGHT_ONE) ? WEIGHT_ONE : b.wt[k];
      if (w == '0 || j >= lim) continue;
      wt = {{(WIDE-W_W){1'b0}}, w};
      for (r = 0; r < NUM_ROWS; r++) begin
        row = wide(palette_img[j][r*NUM_COLS+3]) <<< 16;
        for (c = 0; c < 3; c++) row += wide(palette_img[j][r*NUM_COLS+c]) * pos[c];
        acc[r] += (row >>> 16) * wt;
      end
    end
    res.sat = 1'b0;
    for (r = 0; r < NUM_ROWS; r++) begin
      tot = acc[r] >>> 15;
      if (tot > SAT_HI) begin
        tot = SAT_HI;
        res.sat = 1'b1;
      end else if (tot < SAT_LO) begin
        tot = SAT_LO;
        res.sat = 1'b1;
      end
      res.xyz[r] = tot[Q_W-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // beat builders and random content
  // --------------------------------------------------------------------------

  function automatic beat_t load_beat(input logic [5:0] joint, input logic [ELEM_W-1:0] elem,
                                      input logic [Q_W-1:0] value);
    beat_t b;
    b = '0;
    b.cmd   = CMD_LOAD;
    b.joint = joint;
    b.elem  = elem;
    b.value = value;
    return b;
  endfunction

  // wts packs weight 3 down to weight 0
  function automatic beat_t skin_beat(input logic [Q_W-1:0] px, input logic [Q_W-1:0] py,
                                      input logic [Q_W-1:0] pz, input logic [31:0] jidx,
                                      input logic [4*W_W-1:0] wts);
    beat_t b;
    b = '0;
    b.cmd  = CMD_SKIN;
    b.px   = px;
    b.py   = py;
    b.pz   = pz;
    b.jidx = jidx;
    b.wt   = wts;
    return b;
  endfunction

  // mostly plausible matrix terms within +-2.0, sometimes any pattern
  function automatic logic [Q_W-1:0] rand_entry();
    if ($urandom_range(99) < 60) return $urandom_range(32'h3_FFFF) - 32'h2_0000;
    return $urandom;
  endfunction

  function automatic logic [Q_W-1:0] rand_coord();
    if ($urandom_range(1)) return $urandom;
    return $urandom_range(32'h07FF_FFFF) - 32'h0400_0000;
  endfunction

  function automatic logic [W_W-1:0] rand_weight();
    int r;
    r = $urandom_range(99);
    if (r < 10) return WEIGHT_ONE;
    if (r < 25) return W_W'($urandom_range(16'hFFFF, 16'h8001));
    return W_W'($urandom_range(WEIGHT_ONE, 1));
  endfunction

  // influences only name joints whose matrix is complete, or indices past the palette
  function automatic beat_t random_skin();
    beat_t b;
    int    k;
    int    r;
    b = skin_beat(rand_coord(), rand_coord(), rand_coord(), '0, '0);
    for (k = 0; k < PORT_INF; k++) begin
      r = $urandom_range(99);
      if (ready_joints.size() == 0 || r < 15) begin
        b.jidx[IDX_W*k +: IDX_W] = IDX_W'($urandom_range(255, MAX_JOINTS_DEF));
        b.wt[k] = W_W'($urandom_range(16'hFFFF));
      end else begin
        b.jidx[IDX_W*k +: IDX_W] =
          IDX_W'(ready_joints[$urandom_range(ready_joints.size() - 1)]);
        b.wt[k] = (r < 30) ? '0 : rand_weight();
      end
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // shared driving tasks
  // --------------------------------------------------------------------------

  // random idle cycles first, then hold the beat until it is taken
  task automatic send_beat(input beat_t b);
    while (!in_quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= b.cmd;
    load_joint    <= b.joint;
    load_element  <= b.elem;
    load_value    <= b.value;
    pos_x         <= b.px;
    pos_y         <= b.py;
    pos_z         <= b.pz;
    joint_indices <= b.jidx;
    weight_0      <= b.wt[0];
    weight_1      <= b.wt[1];
    weight_2      <= b.wt[2];
    weight_3      <= b.wt[3];
    do @(posedge clk); while (in_stall);
    if (b.cmd == CMD_SKIN) pending_blends.push_back(blend_vertex(b));
    else store_element(b);
  endtask

  // only with the pipe drained; loads leave no result, so give them the latency too
  task automatic write_joint_count(input logic [JC_W-1:0] count);
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    joints_in_use = count;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // joint 0 is identity with a translation, joint 63 is full of extreme terms,
  // plus two loads to elements past the matrix that must not land anywhere
  task automatic test_palette_load();
    logic [Q_W-1:0] ident [MAT_ENTRIES];
    int             e;
    ident = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000,
              32'h0, 32'h0001_0000, 32'h0, 32'hFFFE_0000,
              32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000};
    for (e = 0; e < MAT_ENTRIES; e++) send_beat(load_beat(6'd0, ELEM_W'(e), ident[e]));
    for (e = 0; e < MAT_ENTRIES; e++) begin
      send_beat(load_beat(6'd63, ELEM_W'(e),
                          (e < 4) ? Q_MAX : (e < 8) ? Q_MIN : (e % 2) ? Q_MIN : Q_MAX));
    end
    send_beat(load_beat(6'd0, ELEM_W'(12), 32'hDEAD_BEEF));
    send_beat(load_beat(6'd0, ELEM_W'(15), 32'h1234_5678));
  endtask

  task automatic test_skin_extremes();
    // plain identity, the other three point past the palette with weight
    send_beat(skin_beat(32'h0001_8000, 32'hFFFC_C000, 32'h0, 32'hFFFF_FF00,
                        {16'h8000, 16'h8000, 16'h8000, WEIGHT_ONE}));
    // weight above one behaves as one
    send_beat(skin_beat(32'h0001_8000, 32'hFFFC_C000, 32'h0, 32'h0, {48'h0, 16'hFFFF}));
    // every weight zero gives the origin
    send_beat(skin_beat(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0, 64'h0));
    // half of joint 0 and half of joint 63
    send_beat(skin_beat(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0010, 32'h0000_3F00,
                        {32'h0, 16'h4000, 16'h4000}));
    // extreme joint at both ends of the coordinate range clamps
    send_beat(skin_beat(Q_MAX, Q_MAX, Q_MAX, 32'h3F3F_3F3F, {48'h0, WEIGHT_ONE}));
    send_beat(skin_beat(Q_MIN, Q_MIN, Q_MIN, 32'h3F3F_3F3F, {48'h0, WEIGHT_ONE}));
    // identity whose translation pushes x over the top and y under the bottom
    send_beat(skin_beat(Q_MAX, 32'h0, 32'h0, 32'h0, {48'h0, WEIGHT_ONE}));
    send_beat(skin_beat(32'h0, Q_MIN, Q_MIN, 32'h0, {48'h0, WEIGHT_ONE}));
    // four influences on one joint with odd weights
    send_beat(skin_beat(32'h1234_5678, 32'hEDCB_A988, 32'h0000_0001, 32'h0,
                        {16'h7FFF, 16'h3039, 16'h0002, 16'h0001}));
    // alternating weight bit patterns, one above one and one below
    send_beat(skin_beat(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0001, 32'h003F_003F,
                        {16'h0, 16'h0, 16'hAAAA, 16'h5555}));
    // negative lsb with a tiny weight rounds toward minus infinity
    send_beat(skin_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, {48'h0, 16'h0001}));
  endtask

  // zero joints in use, one joint, the widest count, then back to the palette size
  task automatic test_joint_count();
    write_joint_count(JC_W'(0));
    send_beat(skin_beat(32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0000_3F00,
                        {32'h0, 16'h4000, WEIGHT_ONE}));
    write_joint_count(JC_W'(1));
    send_beat(skin_beat(32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0000_3F00,
                        {32'h0, 16'h4000, WEIGHT_ONE}));
    write_joint_count(JC_W'(127));
    send_beat(skin_beat(32'h0000_0200, 32'h0000_0300, 32'h0000_0400, 32'h0000_3F00,
                        {32'h0, 16'h4000, 16'h2000}));
    write_joint_count(JOINT_COUNT_RESET);
    send_beat(skin_beat(32'h0000_0200, 32'h0000_0300, 32'h0000_0400, 32'h0000_3F00,
                        {32'h0, 16'h4000, 16'h2000}));
  endtask

  // mostly skins, with whole matrix loads and stray single loads mixed in
  task automatic test_random_stream();
    logic [JC_W-1:0] phase_count [4];
    beat_t           b;
    int              phase;
    int              n;
    int              r;
    int              e;
    int              jn;
    phase_count = '{JC_W'(127), JC_W'($urandom_range(63, 1)),
                    JC_W'($urandom_range(126, 65)), JOINT_COUNT_RESET};
    for (phase = 0; phase < 4; phase++) begin
      write_joint_count(phase_count[phase]);
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 18) begin
          jn = $urandom_range(MAX_JOINTS_DEF - 1);
          for (e = 0; e < MAT_ENTRIES; e++) send_beat(load_beat(6'(jn), ELEM_W'(e), rand_entry()));
          n += MAT_ENTRIES;
        end else if (r < 26) begin
          b = load_beat(6'($urandom_range(63)), ELEM_W'($urandom_range(15)), $urandom);
          send_beat(b);
          // loads past the matrix are dropped by the block
          if (b.elem < MAT_ENTRIES) n++;
        end else begin
          repeat ($urandom_range(6, 1)) begin
            send_beat(random_skin());
            n++;
          end
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills up
  task automatic test_back_pressure();
    in_quiet = 1'b1;
    hold_req = HOLD_CYCLES;
    repeat (40) send_beat(random_skin());
    in_quiet = 1'b0;
  endtask

  // no idling on either side for a long stretch
  task automatic test_full_rate();
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    repeat (60) send_beat(random_skin());
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // receiver, checker and watchdog
  // --------------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !out_quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : result_check
    blend_t got;
    blend_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.xyz[0] = skinned_x;
      got.xyz[1] = skinned_y;
      got.xyz[2] = skinned_z;
      got.sat    = saturated;
      if (pending_blends.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: x=%h y=%h z=%h sat=%b",
                   $time, got.xyz[0], got.xyz[1], got.xyz[2], got.sat);
      end else begin
        want = pending_blends.pop_front();
        if (got.xyz[0] !== want.xyz[0] || got.xyz[1] !== want.xyz[1] ||
            got.xyz[2] !== want.xyz[2] || got.sat !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                     $time, want.xyz[0], want.xyz[1], want.xyz[2], want.sat,
                     got.xyz[0], got.xyz[1], got.xyz[2], got.sat);
        end
      end
    end
  end

  // any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin
    int j;
    mismatches   = 0;
    quiet_cycles = 0;
    in_quiet     = 1'b0;
    out_quiet    = 1'b0;
    hold_req     = 0;
    joints_in_use = JOINT_COUNT_RESET;
    for (j = 0; j < MAX_JOINTS_DEF; j++) begin
      entry_written[j] = '0;
      joint_ready[j]   = 1'b0;
    end
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    command       <= CMD_LOAD;
    load_joint    <= '0;
    load_element  <= '0;
    load_value    <= '0;
    pos_x         <= '0;
    pos_y         <= '0;
    pos_z         <= '0;
    joint_indices <= '0;
    weight_0      <= '0;
    weight_1      <= '0;
    weight_2      <= '0;
    weight_3      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_palette_load();
    test_skin_extremes();
    test_joint_count();
    test_random_stream();
    test_back_pressure();
    test_full_rate();

    // drain, then leave room for any stray late result
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (4 * RESULT_LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_blends.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
